>>> sv/ght_pkg.sv
// ----------------------------------------------------------------------------
// ght_pkg
// Shared types and constants for the generational handle table.
// ----------------------------------------------------------------------------
package ght_pkg;

	localparam int SLOTS    = 4096;
	localparam int ADDR_W   = $clog2(SLOTS);
	localparam int FUNC_W   = 2;
	localparam int PTR_W    = 64;
	localparam int SLOT_W   = 12;
	localparam int SERIAL_W = 31;

	localparam logic [SERIAL_W-1:0] SERIAL_MAX = {SERIAL_W{1'b1}};

	localparam logic [FUNC_W-1:0] FN_ALLOC  = 2'd0;
	localparam logic [FUNC_W-1:0] FN_FREE   = 2'd1;
	localparam logic [FUNC_W-1:0] FN_LOOKUP = 2'd2;

	typedef logic [ADDR_W-1:0] addr_t;

	typedef struct packed {
		logic [SERIAL_W-1:0] serial;
		logic [SLOT_W-1:0]   next;
	} meta_t;

endpackage

>>> sv/ght_req_if.sv
// ----------------------------------------------------------------------------
// ght_req_if
// Request channel of the handle table: valid, ready and one request.
// ----------------------------------------------------------------------------
interface ght_req_if import ght_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [FUNC_W-1:0]   func;
	logic [PTR_W-1:0]    obj_ptr;
	logic [SLOT_W-1:0]   slot_index;
	logic [SERIAL_W-1:0] serial_in;

	modport source (output valid, func, obj_ptr, slot_index, serial_in, input ready);
	modport sink   (input valid, func, obj_ptr, slot_index, serial_in, output ready);
	modport mon    (input valid, ready, func, obj_ptr, slot_index, serial_in);
endinterface

>>> sv/ght_rsp_if.sv
// ----------------------------------------------------------------------------
// ght_rsp_if
// Response channel of the handle table: valid, ready and one result.
// ----------------------------------------------------------------------------
interface ght_rsp_if import ght_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                ok;
	logic [SLOT_W-1:0]   slot_out;
	logic [SERIAL_W-1:0] serial_out;
	logic [PTR_W-1:0]    ptr_out;

	modport source (output valid, ok, slot_out, serial_out, ptr_out, input ready);
	modport sink   (input valid, ok, slot_out, serial_out, ptr_out, output ready);
	modport mon    (input valid, ready, ok, slot_out, serial_out, ptr_out);
endinterface

>>> sv/generational_handle_table_core.sv
// Flow: a request is captured together with its slot memory reads on its transaction and
// executes in ST_EXEC, where its result is registered onto the response channel.
// One request at a time, set by the read and write-back of the slot memories, which have
// registered reads; a result that waits holds the next request.
// Reset: a clearing pass over all SLOTS (4096) entries initializes the serial and free-link
// memory; no request is taken until it ends. Pointer memory is not initialized.
// ----------------------------------------------------------------------------
// generational_handle_table_core
// Fixed-size handle table with generation serials and a linked free list.
// ----------------------------------------------------------------------------
module generational_handle_table_core import ght_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	ght_req_if.sink    req,
	ght_rsp_if.source  rsp
);

	typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_EXEC} state_t;

	state_t              state_q;
	addr_t               clr_cnt_q;
	logic [SLOT_W-1:0]   free_head_q;
	logic [SERIAL_W-1:0] serial_cnt_q;
	logic                rsp_valid_q;

	logic [FUNC_W-1:0]   func_s1;
	logic [PTR_W-1:0]    ptr_s1;
	logic [SLOT_W-1:0]   idx_s1;
	logic [SERIAL_W-1:0] ser_s1;
	meta_t               meta_rd_s1;
	logic [PTR_W-1:0]    ptr_rd_s1;

	logic                rsp_ok_q;
	logic [SLOT_W-1:0]   rsp_slot_q;
	logic [SERIAL_W-1:0] rsp_serial_q;
	logic [PTR_W-1:0]    rsp_ptr_q;

	meta_t               meta_mem [SLOTS];
	logic [PTR_W-1:0]    ptr_mem  [SLOTS];

	logic                req_fire;
	logic                exec_go;
	addr_t               rd_addr;
	logic                idx_ok;
	logic                head_ok;
	logic [SERIAL_W-1:0] serial_nxt;

	logic                res_ok;
	logic [SLOT_W-1:0]   res_slot;
	logic [SERIAL_W-1:0] res_serial;
	logic [PTR_W-1:0]    res_ptr;
	logic                op_meta_we;
	addr_t               op_meta_wa;
	meta_t               op_meta_wd;
	logic                ptr_we;
	logic                head_we;
	logic [SLOT_W-1:0]   head_nxt;
	logic                ser_we;

	logic                meta_we;
	addr_t               meta_wa;
	meta_t               meta_wd;

	assign req.ready  = (state_q == ST_IDLE);
	assign req_fire   = req.valid && req.ready;
	assign exec_go    = (state_q == ST_EXEC) && (!rsp_valid_q || rsp.ready);
	assign rd_addr    = (req.func == FN_ALLOC) ? addr_t'(free_head_q) : addr_t'(req.slot_index);
	assign idx_ok     = (idx_s1 != '0) && (32'(idx_s1) < SLOTS);
	assign head_ok    = (free_head_q != '0) && (32'(free_head_q) < SLOTS);
	assign serial_nxt = (serial_cnt_q == SERIAL_MAX) ? SERIAL_W'(1) : serial_cnt_q + SERIAL_W'(1);

	always_comb begin
		res_ok     = 1'b0;
		res_slot   = '0;
		res_serial = '0;
		res_ptr    = '0;
		op_meta_we = 1'b0;
		op_meta_wa = addr_t'(idx_s1);
		op_meta_wd = '{serial: '0, next: free_head_q};
		ptr_we     = 1'b0;
		head_we    = 1'b0;
		head_nxt   = idx_s1;
		ser_we     = 1'b0;
		unique case (func_s1)
			FN_ALLOC: begin
				if (head_ok) begin
					res_ok     = 1'b1;
					res_slot   = free_head_q;
					res_serial = serial_nxt;
					op_meta_we = 1'b1;
					op_meta_wa = addr_t'(free_head_q);
					op_meta_wd = '{serial: serial_nxt, next: meta_rd_s1.next};
					ptr_we     = 1'b1;
					head_we    = 1'b1;
					head_nxt   = meta_rd_s1.next;
					ser_we     = 1'b1;
				end
			end
			FN_FREE: begin
				if (idx_ok) begin
					res_ok     = 1'b1;
					op_meta_we = 1'b1;
					head_we    = 1'b1;
				end
			end
			FN_LOOKUP: begin
				if (idx_ok && (ser_s1 != '0) && (meta_rd_s1.serial == ser_s1)) begin
					res_ok  = 1'b1;
					res_ptr = ptr_rd_s1;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		if (state_q == ST_CLEAR) begin
			meta_we = 1'b1;
			meta_wa = clr_cnt_q;
			meta_wd = '{serial: '0,
				next: (clr_cnt_q == addr_t'(SLOTS - 1)) ? '0
					: SLOT_W'(clr_cnt_q) + SLOT_W'(1)};
		end else begin
			meta_we = exec_go && op_meta_we;
			meta_wa = op_meta_wa;
			meta_wd = op_meta_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (meta_we) begin
			meta_mem[meta_wa] <= meta_wd;
		end
		if (req_fire) begin
			meta_rd_s1 <= meta_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (exec_go && ptr_we) begin
			ptr_mem[addr_t'(free_head_q)] <= ptr_s1;
		end
		if (req_fire) begin
			ptr_rd_s1 <= ptr_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			func_s1 <= req.func;
			ptr_s1  <= req.obj_ptr;
			idx_s1  <= req.slot_index;
			ser_s1  <= req.serial_in;
		end
		if (exec_go) begin
			rsp_ok_q     <= res_ok;
			rsp_slot_q   <= res_slot;
			rsp_serial_q <= res_serial;
			rsp_ptr_q    <= res_ptr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_cnt_q    <= '0;
			free_head_q  <= SLOT_W'(1);
			serial_cnt_q <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + addr_t'(1);
					if (clr_cnt_q == addr_t'(SLOTS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_fire) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (exec_go) begin
						state_q <= ST_IDLE;
						if (head_we) begin
							free_head_q <= head_nxt;
						end
						if (ser_we) begin
							serial_cnt_q <= serial_nxt;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (exec_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.ok         = rsp_ok_q;
	assign rsp.slot_out   = rsp_slot_q;
	assign rsp.serial_out = rsp_serial_q;
	assign rsp.ptr_out    = rsp_ptr_q;

endmodule

>>> sv/ght_checker.sv
// ----------------------------------------------------------------------------
// ght_checker
// Port-level checks on the handle table, attached to generational_handle_table_core by bind.
// ----------------------------------------------------------------------------
module ght_checker import ght_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input logic                rsp_ok,
	input logic [SLOT_W-1:0]   rsp_slot_out,
	input logic [SERIAL_W-1:0] rsp_serial_out,
	input logic [PTR_W-1:0]    rsp_ptr_out
);

	// A result waiting on the response channel stays until it is taken.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped before its transaction");

	// Each request occupies the block: ready drops once a request is taken.
	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while the previous one executes");

	// A handed-out slot always comes with a nonzero serial.
	a_alloc_serial: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_slot_out != '0) |-> rsp_ok && (rsp_serial_out != '0))
		else $error("allocated slot without a valid serial");

	// A returned pointer only comes from a successful lookup.
	a_lookup_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_ptr_out != '0) |-> rsp_ok && (rsp_slot_out == '0))
		else $error("pointer returned by a failed or non-lookup request");

endmodule

bind generational_handle_table_core ght_checker u_ght_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_ok         (rsp.ok),
	.rsp_slot_out   (rsp.slot_out),
	.rsp_serial_out (rsp.serial_out),
	.rsp_ptr_out    (rsp.ptr_out)
);
